>>> sv/ppe_pkg.sv
// Package with the shared types, constants and tables of the permutation phase extractor.
`default_nettype none
package ppe_pkg;

  // Build-time limits of the block.
  localparam int MAX_QUBITS   = 6;
  localparam int CORDIC_STEPS = 14;

  // Field and internal widths.
  localparam int DATA_W     = 16;
  localparam int TOL_W      = 15;
  localparam int QUBIT_W    = 3;
  localparam int IDX_W      = 6;
  localparam int PHASE_W    = 16;
  localparam int CNT_W      = MAX_QUBITS;
  localparam int MAG_W      = 2 * DATA_W;
  localparam int CORDIC_W   = DATA_W + 4;
  localparam int ANGLE_W    = 21;
  localparam int ATAN_DEPTH = 24;
  localparam int STEP_W     = $clog2(ATAN_DEPTH);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TOL_W;

  // Angle constants, 16 fractional bits for the accumulator, Q3.13 for the result.
  localparam logic signed [ANGLE_W-1:0] ANGLE_PI  = ANGLE_W'(205887);
  localparam logic signed [ANGLE_W-1:0] PHASE_MAX = ANGLE_W'(25736);
  localparam logic signed [ANGLE_W-1:0] ROUND_HALF = ANGLE_W'(4);

  // Reset values of the configuration registers.
  localparam logic [QUBIT_W-1:0] QUBIT_RESET = QUBIT_W'(1);
  localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(16);

  // atan(2^-i) with 16 fractional bits, rounded to nearest.
  localparam logic [ANGLE_W-1:0] ATAN_TABLE [ATAN_DEPTH] = '{
    ANGLE_W'(51472), ANGLE_W'(30386), ANGLE_W'(16055), ANGLE_W'(8150),
    ANGLE_W'(4091),  ANGLE_W'(2047),  ANGLE_W'(1024),  ANGLE_W'(512),
    ANGLE_W'(256),   ANGLE_W'(128),   ANGLE_W'(64),    ANGLE_W'(32),
    ANGLE_W'(16),    ANGLE_W'(8),     ANGLE_W'(4),     ANGLE_W'(2),
    ANGLE_W'(1),     ANGLE_W'(0),     ANGLE_W'(0),     ANGLE_W'(0),
    ANGLE_W'(0),     ANGLE_W'(0),     ANGLE_W'(0),     ANGLE_W'(0)
  };

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUBIT_COUNT    = 2'd0,
    CFG_ZERO_TOLERANCE = 2'd1
  } cfg_index_e;

  // Row status codes.
  typedef enum logic [1:0] {
    ROW_OK      = 2'd0,
    ROW_EMPTY   = 2'd1,
    ROW_SEVERAL = 2'd2
  } row_status_e;

  // One input word.
  typedef struct packed {
    logic signed [DATA_W-1:0] entry_real;
    logic signed [DATA_W-1:0] entry_imag;
  } entry_t;

  // One result word.
  typedef struct packed {
    logic [IDX_W-1:0]          row_index;
    logic [IDX_W-1:0]          column_index;
    logic signed [PHASE_W-1:0] phase;
    row_status_e               row_status;
    logic                      matrix_failed;
    logic                      last_row;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_entry;
    logic square;
    logic update;
    logic start;
    logic step;
    logic finish;
  } ppe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic row_end;
    logic cordic_last;
    logic out_free;
  } ppe_status_t;

endpackage
`default_nettype wire

>>> sv/permutation_phase_extractor.sv
// Top level of the permutation phase extractor: controller plus datapath.
`default_nettype none
// Matrix entries arrive as words in row-major order, 2^qubit_count per row.
// Each entry passes capture, square, then zero test and row update through the
// shared multiply and compare path, and in_ready_o is high only in the idle
// state, so no new entry is taken before the last one is through. After the last
// entry of a row the block captures the row result, runs the iterative CORDIC at
// one micro-rotation per cycle, then, once the output register is free, rounds
// into it before it takes the next entry. The result sits in an output register,
// so the next row is accepted while an earlier word waits; a second finished word
// waits in place until the first is taken. Configuration words are taken in any
// cycle and must only be written while the block is idle; writing qubit_count
// restarts the matrix.
module permutation_phase_extractor
  import ppe_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire entry_t                in_word_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output result_t                    out_word_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  ppe_cmd_t    cmd;
  ppe_status_t status;

  assign cfg_ready_o = 1'b1;

  ppe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ppe_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
`default_nettype wire

>>> sv/ppe_ctrl.sv
// Controller state machine that sequences entry checks and the per-row CORDIC.
`default_nettype none
module ppe_ctrl
  import ppe_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire ppe_status_t status_i,
  output ppe_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SQUARE = 6'b000010,
    S_UPDATE = 6'b000100,
    S_START  = 6'b001000,
    S_CORDIC = 6'b010000,
    S_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_entry = 1'b1;
          state_d = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d = status_i.row_end ? S_START : S_IDLE;
      end
      S_START: begin
        cmd_o.start = 1'b1;
        state_d = S_CORDIC;
      end
      S_CORDIC: begin
        cmd_o.step = 1'b1;
        if (status_i.cordic_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> sv/ppe_datapath.sv
// Datapath: configuration, zero test, row tracking, iterative CORDIC and output register.
`default_nettype none
module ppe_datapath
  import ppe_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire entry_t                in_word_i,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output result_t                    out_word_o,
  input  wire ppe_cmd_t              cmd_i,
  output ppe_status_t                status_o
);

  // Configuration registers.
  logic [QUBIT_W-1:0] qubit_q;
  logic [TOL_W-1:0]   tol_q;
  logic               cfg_qubit_wr;

  assign cfg_qubit_wr = cfg_valid_i && (cfg_index_i == CFG_QUBIT_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qubit_q <= QUBIT_RESET;
      tol_q   <= TOL_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_QUBIT_COUNT) begin
        qubit_q <= cfg_data_i[QUBIT_W-1:0];
      end else if (cfg_index_i == CFG_ZERO_TOLERANCE) begin
        tol_q <= cfg_data_i[TOL_W-1:0];
      end
    end
  end

  // Mask of the highest column and row index for the clamped qubit count.
  logic [CNT_W-1:0] edge_mask;

  always_comb begin
    int n_eff;
    n_eff = int'(qubit_q);
    if (n_eff < 1) begin
      n_eff = 1;
    end
    if (n_eff > MAX_QUBITS) begin
      n_eff = MAX_QUBITS;
    end
    for (int b = 0; b < CNT_W; b++) begin
      edge_mask[b] = (b < n_eff);
    end
  end

  // Entry register and squares.
  logic signed [DATA_W-1:0] entry_re_q, entry_im_q;
  logic signed [MAG_W-1:0]  prod_re, prod_im;
  logic [2*TOL_W-1:0]       tol_sq;
  logic [MAG_W-1:0]         sq_re_q, sq_im_q;
  logic [2*TOL_W-1:0]       tol_sq_q;

  assign prod_re = entry_re_q * entry_re_q;
  assign prod_im = entry_im_q * entry_im_q;
  assign tol_sq  = tol_q * tol_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_entry) begin
      entry_re_q <= in_word_i.entry_real;
      entry_im_q <= in_word_i.entry_imag;
    end
    if (cmd_i.square) begin
      sq_re_q  <= unsigned'(prod_re);
      sq_im_q  <= unsigned'(prod_im);
      tol_sq_q <= tol_sq;
    end
  end

  // Zero test on the squared magnitude; the sum of two squares fits in MAG_W bits.
  logic [MAG_W-1:0] mag;
  logic             nonzero;

  assign mag     = sq_re_q + sq_im_q;
  assign nonzero = mag >= MAG_W'(tol_sq_q);

  // Row state.
  logic [CNT_W-1:0]         column_q, row_q, found_col_q;
  logic                     found_q, several_q, failed_q;
  logic signed [DATA_W-1:0] found_re_q, found_im_q;
  logic                     row_end, last_row;
  row_status_e              row_status;
  logic                     row_failed;

  assign row_end    = (column_q == edge_mask);
  assign last_row   = (row_q == edge_mask);
  assign row_failed = failed_q || (row_status != ROW_OK);

  always_comb begin
    if (several_q) begin
      row_status = ROW_SEVERAL;
    end else if (!found_q) begin
      row_status = ROW_EMPTY;
    end else begin
      row_status = ROW_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      row_q       <= '0;
      found_q     <= 1'b0;
      several_q   <= 1'b0;
      found_col_q <= '0;
      found_re_q  <= '0;
      found_im_q  <= '0;
      failed_q    <= 1'b0;
    end else if (cfg_qubit_wr) begin
      column_q    <= '0;
      row_q       <= '0;
      found_q     <= 1'b0;
      several_q   <= 1'b0;
      found_col_q <= '0;
      found_re_q  <= '0;
      found_im_q  <= '0;
      failed_q    <= 1'b0;
    end else if (cmd_i.update) begin
      // Keep the first nonzero entry, flag any further one.
      if (nonzero) begin
        if (found_q) begin
          several_q <= 1'b1;
        end else begin
          found_q     <= 1'b1;
          found_col_q <= column_q;
          found_re_q  <= entry_re_q;
          found_im_q  <= entry_im_q;
        end
      end
      if (!row_end) begin
        column_q <= column_q + CNT_W'(1);
      end
    end else if (cmd_i.start) begin
      // The row result is captured; clear the row and advance the matrix.
      column_q    <= '0;
      found_q     <= 1'b0;
      several_q   <= 1'b0;
      found_col_q <= '0;
      found_re_q  <= '0;
      found_im_q  <= '0;
      if (last_row) begin
        row_q    <= '0;
        failed_q <= 1'b0;
      end else begin
        row_q    <= row_q + CNT_W'(1);
        failed_q <= row_failed;
      end
    end
  end

  // Captured row result, waiting for the phase.
  logic [CNT_W-1:0] pend_row_q, pend_col_q;
  row_status_e      pend_status_q;
  logic             pend_failed_q, pend_last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pend_row_q    <= row_q;
      pend_col_q    <= (row_status == ROW_OK) ? found_col_q : '0;
      pend_status_q <= row_status;
      pend_failed_q <= row_failed;
      pend_last_q   <= last_row;
    end
  end

  // Vectoring CORDIC, one micro-rotation per cycle.
  logic signed [CORDIC_W-1:0] x_q, y_q, x_sh, y_sh, re_ext, im_ext;
  logic signed [ANGLE_W-1:0]  z_q, atan_step;
  logic [STEP_W-1:0]          step_q;

  assign re_ext    = CORDIC_W'(found_re_q);
  assign im_ext    = CORDIC_W'(found_im_q);
  assign x_sh      = x_q >>> step_q;
  assign y_sh      = y_q >>> step_q;
  assign atan_step = signed'(ATAN_TABLE[step_q]);

  assign status_o.cordic_last = (step_q == STEP_W'(CORDIC_STEPS - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      step_q <= '0;
      if (found_re_q < 0) begin
        x_q <= -re_ext;
        y_q <= -im_ext;
        z_q <= (found_im_q >= 0) ? ANGLE_PI : -ANGLE_PI;
      end else begin
        x_q <= re_ext;
        y_q <= im_ext;
        z_q <= '0;
      end
    end else if (cmd_i.step) begin
      step_q <= step_q + STEP_W'(1);
      if (y_q > 0) begin
        x_q <= x_q + y_sh;
        y_q <= y_q - x_sh;
        z_q <= z_q + atan_step;
      end else if (y_q < 0) begin
        x_q <= x_q - y_sh;
        y_q <= y_q + x_sh;
        z_q <= z_q - atan_step;
      end
    end
  end

  // Round the angle to Q3.13 and saturate.
  logic signed [ANGLE_W-1:0] z_round, z_sat;

  always_comb begin
    z_round = (z_q + ROUND_HALF) >>> 3;
    if (z_round > PHASE_MAX) begin
      z_sat = PHASE_MAX;
    end else if (z_round < -PHASE_MAX) begin
      z_sat = -PHASE_MAX;
    end else begin
      z_sat = z_round;
    end
  end

  // Output register.
  logic    out_valid_q;
  result_t out_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.row_end  = row_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.row_index     <= IDX_W'(pend_row_q);
      out_q.column_index  <= IDX_W'(pend_col_q);
      out_q.phase         <= (pend_status_q == ROW_OK) ? PHASE_W'(z_sat) : '0;
      out_q.row_status    <= pend_status_q;
      out_q.matrix_failed <= pend_failed_q;
      out_q.last_row      <= pend_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // A finished word is never dropped: a new one loads only into a free register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || out_ready_i))
    else $error("result word loaded over a pending word");

  // A loaded word is presented in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q)
    else $error("loaded result word not presented");

  // A row that is not ok reports column and phase as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.row_status != ROW_OK) |->
      (out_q.column_index == '0 && out_q.phase == '0))
    else $error("failed row with nonzero column or phase");

  // A failed row always raises the sticky matrix flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.row_status != ROW_OK) |-> out_q.matrix_failed)
    else $error("failed row without matrix_failed");

  // The CORDIC never steps past the end of its angle table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (step_q < STEP_W'(CORDIC_STEPS)))
    else $error("CORDIC step index out of range");

endmodule
`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the permutation phase extractor.
module testbench;
  import ppe_pkg::*;

  // Register indexes that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;

  localparam int     TOTAL_ITEMS   = 1900;
  localparam int     REPORT_LIMIT  = 10;
  localparam int     STALL_LIMIT   = 3000;
  localparam int     SETTLE_CYCLES = 2 * (CORDIC_STEPS + 2) + 8;
  localparam longint HALF_TURN     = 205887;
  localparam longint PHASE_LIMIT   = 25736;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  entry_t                in_word_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  result_t               out_word_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  permutation_phase_extractor dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_word_i,
    .out_valid_o, .out_ready_i, .out_word_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Words waiting to be sent and row results still owed by the block.
  entry_t  entry_backlog[$];
  result_t awaited_rows[$];
  int      items_queued   = 0;
  int      failures       = 0;
  int      send_gap_pct   = 12;
  int      recv_stall_pct = 64;
  int      quiet_cycles   = 0;

  // Shadow of the block's registers and row tracking.
  logic [QUBIT_W-1:0] qubits_reg    = QUBIT_RESET;
  logic [TOL_W-1:0]   tolerance_reg = TOL_RESET;
  int                 col_pos       = 0;
  int                 row_pos       = 0;
  bit                 have_hit      = 1'b0;
  bit                 extra_hit     = 1'b0;
  int                 hit_col       = 0;
  longint             hit_re        = 0;
  longint             hit_im        = 0;
  bit                 matrix_bad    = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Qubit count as the block uses it: zero acts as one, large values clamp.
  function automatic int span_of(input int q);
    if (q < 1) return 1;
    if (q > MAX_QUBITS) return MAX_QUBITS;
    return q;
  endfunction

  // Rounded atan(2^-i) with 16 fractional bits.
  function automatic longint arc_step(input int i);
    case (i)
      0:  return 51472;
      1:  return 30386;
      2:  return 16055;
      3:  return 8150;
      4:  return 4091;
      5:  return 2047;
      6:  return 1024;
      7:  return 512;
      8:  return 256;
      9:  return 128;
      10: return 64;
      11: return 32;
      12: return 16;
      13: return 8;
      14: return 4;
      15: return 2;
      16: return 1;
      default: return 0;
    endcase
  endfunction

  // Vectoring CORDIC atan2 with floor shifts, rounded to Q3.13 and saturated.
  function automatic longint cordic_angle(input longint re, input longint im);
    longint x, y, z, xs, ys;
    x = re;
    y = im;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + arc_step(i);
      end else if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z = z - arc_step(i);
      end
    end
    z = (z + 4) >>> 3;
    if (z > PHASE_LIMIT) z = PHASE_LIMIT;
    if (z < -PHASE_LIMIT) z = -PHASE_LIMIT;
    return z;
  endfunction

  task automatic restart_row();
    col_pos   = 0;
    have_hit  = 1'b0;
    extra_hit = 1'b0;
    hit_col   = 0;
    hit_re    = 0;
    hit_im    = 0;
  endtask

  // Track one accepted entry; at a row end, queue the row result it causes.
  task automatic fold_entry(input entry_t e);
    longint      re, im, mag, floor_sq;
    int          row_len;
    row_status_e status;
    result_t     r;
    row_len  = 1 << span_of(qubits_reg);
    re       = $signed(e.entry_real);
    im       = $signed(e.entry_imag);
    mag      = re * re + im * im;
    floor_sq = longint'(tolerance_reg) * longint'(tolerance_reg);
    if (mag >= floor_sq) begin
      if (have_hit) begin
        extra_hit = 1'b1;
      end else begin
        have_hit = 1'b1;
        hit_col  = col_pos;
        hit_re   = re;
        hit_im   = im;
      end
    end
    if (col_pos + 1 < row_len) begin
      col_pos++;
      return;
    end
    if (extra_hit) status = ROW_SEVERAL;
    else if (!have_hit) status = ROW_EMPTY;
    else status = ROW_OK;
    r = '0;
    r.row_index     = IDX_W'(row_pos);
    r.row_status    = status;
    r.matrix_failed = matrix_bad || (status != ROW_OK);
    r.last_row      = (row_pos + 1 >= row_len);
    if (status == ROW_OK) begin
      r.column_index = IDX_W'(hit_col);
      r.phase        = PHASE_W'(cordic_angle(hit_re, hit_im));
    end
    awaited_rows.push_back(r);
    restart_row();
    if (r.last_row) begin
      row_pos    = 0;
      matrix_bad = 1'b0;
    end else begin
      row_pos++;
      matrix_bad = r.matrix_failed;
    end
  endtask

  // Mirror of a register write; a new qubit count restarts the matrix.
  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_QUBIT_COUNT: begin
        qubits_reg = data[QUBIT_W-1:0];
        row_pos    = 0;
        matrix_bad = 1'b0;
        restart_row();
      end
      CFG_ZERO_TOLERANCE: tolerance_reg = data;
      default: ;
    endcase
  endtask

  // Entry source: present the next word once the previous one is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) fold_entry(in_word_i);
      if (!in_valid_i || in_ready_o) begin
        if (entry_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_word_i  <= entry_backlog.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result sink: compare each accepted word with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_rows.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("unexpected row result: row %0d col %0d phase %0d status %0d",
                     out_word_o.row_index, out_word_o.column_index,
                     $signed(out_word_o.phase), out_word_o.row_status);
        end else begin
          want = awaited_rows.pop_front();
          if (out_word_o.row_index !== want.row_index ||
              out_word_o.column_index !== want.column_index ||
              out_word_o.phase !== want.phase ||
              out_word_o.row_status !== want.row_status ||
              out_word_o.matrix_failed !== want.matrix_failed ||
              out_word_o.last_row !== want.last_row) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
              $display("row mismatch, expected: row %0d col %0d phase %0d status %0d fail %0b last %0b",
                       want.row_index, want.column_index, $signed(want.phase),
                       want.row_status, want.matrix_failed, want.last_row);
              $display("row mismatch, actual:   row %0d col %0d phase %0d status %0d fail %0b last %0b",
                       out_word_o.row_index, out_word_o.column_index,
                       $signed(out_word_o.phase), out_word_o.row_status,
                       out_word_o.matrix_failed, out_word_o.last_row);
            end
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run if no channel moves a word for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("permutation_phase_extractor verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic set_pace(input int mode);
    case (mode)
      0: begin send_gap_pct = 12; recv_stall_pct = 64; end
      1: begin send_gap_pct = 64; recv_stall_pct = 12; end
      default: begin send_gap_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  // Wait until every word is sent and every row result has come back.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (entry_backlog.size() != 0 || in_valid_i || awaited_rows.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    apply_register(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_word(input entry_t e);
    entry_backlog.push_back(e);
    items_queued++;
  endtask

  task automatic queue_entry(input int re, input int im);
    entry_t e;
    e.entry_real = re[DATA_W-1:0];
    e.entry_imag = im[DATA_W-1:0];
    queue_word(e);
  endtask

  // Entry at or above the zero threshold; sometimes exactly on it.
  function automatic entry_t live_entry(input int tol);
    int     re, im;
    entry_t e;
    if ($urandom_range(7) == 0) begin
      re = tol;
      im = 0;
      if ($urandom_range(1)) begin
        im = re;
        re = 0;
      end
      if ($urandom_range(1)) begin
        re = -re;
        im = -im;
      end
    end else begin
      do begin
        re = int'($urandom_range(65535)) - 32768;
        im = int'($urandom_range(65535)) - 32768;
      end while (longint'(re) * re + longint'(im) * im < longint'(tol) * tol);
    end
    e.entry_real = re[DATA_W-1:0];
    e.entry_imag = im[DATA_W-1:0];
    return e;
  endfunction

  // Entry below the zero threshold, or a live one when it is zero; sometimes just under it.
  function automatic entry_t quiet_entry(input int tol);
    int     re, im;
    entry_t e;
    if (tol == 0) return live_entry(tol);
    if ($urandom_range(9) == 0) begin
      re = ($urandom_range(1)) ? tol - 1 : 1 - tol;
      im = 0;
      if ($urandom_range(1)) begin
        im = re;
        re = 0;
      end
    end else begin
      do begin
        re = int'($urandom_range(2 * tol)) - tol;
        im = int'($urandom_range(2 * tol)) - tol;
      end while (longint'(re) * re + longint'(im) * im >= longint'(tol) * tol);
    end
    e.entry_real = re[DATA_W-1:0];
    e.entry_imag = im[DATA_W-1:0];
    return e;
  endfunction

  // One row: mostly a single nonzero entry, else empty, crowded or raw noise.
  task automatic queue_row(input int row_len, input int tol, input int count);
    int kind, pick, second;
    kind   = $urandom_range(99);
    pick   = $urandom_range(row_len - 1);
    second = (pick + 1 + $urandom_range(row_len - 2)) % row_len;
    for (int c = 0; c < count; c++) begin
      if (kind < 72)
        queue_word((c == pick) ? live_entry(tol) : quiet_entry(tol));
      else if (kind < 81)
        queue_word(quiet_entry(tol));
      else if (kind < 90)
        queue_word((c == pick || c == second || $urandom_range(7) == 0) ?
                   live_entry(tol) : quiet_entry(tol));
      else
        queue_word(entry_t'($urandom()));
    end
  endtask

  initial begin : stimulus
    int q, tol, row_len, rows, phase_no, pick;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset settings: threshold edges, both half-turn signs.
    set_pace(0);
    queue_entry(16, 0);
    queue_entry(15, 0);
    queue_entry(0, 0);
    queue_entry(-32768, 0);
    queue_entry(3, -15);
    queue_entry(0, 0);
    queue_entry(32767, 32767);
    queue_entry(-32768, -32768);
    queue_entry(0, -32768);
    queue_entry(11, 11);
    queue_entry(-32768, -1);
    queue_entry(0, 0);
    wait_drained();
    write_register(CFG_SPARE, 15'h7FFF);
    // Zero tolerance: every entry counts as nonzero, including the origin.
    write_register(CFG_ZERO_TOLERANCE, 15'd0);
    queue_entry(0, 0);
    queue_entry(0, 0);
    queue_entry(32767, -32768);
    queue_entry(-32768, 32767);
    wait_drained();
    // Largest tolerance: only entries of full magnitude survive.
    write_register(CFG_ZERO_TOLERANCE, 15'h7FFF);
    queue_entry(32767, 0);
    queue_entry(32766, 100);
    queue_entry(0, 0);
    queue_entry(-32768, 32767);
    wait_drained();
    // Qubit count of zero behaves as one; upper data bits are ignored.
    write_register(CFG_ZERO_TOLERANCE, TOL_RESET);
    write_register(CFG_QUBIT_COUNT, 15'h7FF8);
    queue_entry(-5, 20);
    queue_entry(0, 0);
    queue_entry(7, 7);
    queue_entry(-100, 0);

    // Random matrices, one setting per phase.
    phase_no = 0;
    while (items_queued < TOTAL_ITEMS) begin
      wait_drained();
      set_pace(items_queued * 3 / TOTAL_ITEMS);
      if (phase_no == 0) q = 7;
      else if (phase_no == 1) q = 5;
      else begin
        pick = $urandom_range(99);
        if (pick < 5) q = 0;
        else if (pick < 30) q = 1;
        else if (pick < 55) q = 2;
        else if (pick < 75) q = 3;
        else if (pick < 83) q = 4;
        else if (pick < 90) q = 5;
        else if (pick < 95) q = 6;
        else q = 7;
      end
      pick = $urandom_range(99);
      if (pick < 35) tol = TOL_RESET;
      else if (pick < 45) tol = 0;
      else if (pick < 52) tol = 32767;
      else if (pick < 80) tol = $urandom_range(4000, 1);
      else tol = $urandom_range(32767);
      write_register(CFG_QUBIT_COUNT, {12'($urandom()), 3'(q)});
      if ($urandom_range(99) < 15)
        write_register($urandom_range(1) ? CFG_RESERVED : CFG_SPARE, 15'($urandom()));
      if ($urandom_range(99) < 85 || phase_no == 0)
        write_register(CFG_ZERO_TOLERANCE, 15'(tol));
      else
        tol = tolerance_reg;

      row_len = 1 << span_of(q);
      if (span_of(q) <= 3) begin
        rows = row_len * $urandom_range(2, 1);
        if ($urandom_range(99) < 30) rows += $urandom_range(row_len - 1, 1);
      end else if (span_of(q) == 4) begin
        rows = row_len;
      end else begin
        rows = $urandom_range(2, 1);
      end
      for (int r = 0; r < rows; r++) queue_row(row_len, tol, row_len);
      // Sometimes leave a row half sent; the next qubit write drops it.
      if ($urandom_range(99) < 30)
        queue_row(row_len, tol, $urandom_range(row_len - 1, 1));
      phase_no++;
    end

    wait_drained();
    if (failures == 0) begin
      $display("permutation_phase_extractor verification clean");
    end else begin
      $display("permutation_phase_extractor verification failed");
    end
    $finish;
  end

endmodule
